### design/mulaw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mulaw_pkg
// Shared types, constants and codec functions for the mu-law channel converter
// ----------------------------------------------------------------------------
package mulaw_pkg;

    localparam int SampleWidth = 16;
    localparam int CodeWidth   = 8;
    localparam int MagWidth    = 14;
    localparam int IndexWidth  = 2;
    localparam int DataWidth   = 2;
    localparam int QueueDepth  = 2;

    localparam logic [15:0] MuBias    = 16'h0084;
    localparam logic [13:0] MuClip    = 14'd8159;
    localparam logic [13:0] MuEncBias = 14'd33;

    localparam logic [IndexWidth-1:0] RegDirection   = 2'd0;
    localparam logic [IndexWidth-1:0] RegChannelMode = 2'd1;

    localparam logic [1:0] ModeMonoPass     = 2'd0;
    localparam logic [1:0] ModeStereoPass   = 2'd1;
    localparam logic [1:0] ModeMonoToStereo = 2'd2;
    localparam logic [1:0] ModeStereoToMono = 2'd3;

    typedef struct packed {
        logic [SampleWidth-1:0] value;
        logic                   dup;
    } mulaw_item_t;

    function automatic logic [SampleWidth-1:0] mu_decode(input logic [CodeWidth-1:0] code);
        logic [7:0]  v;
        logic [15:0] t;
        logic [15:0] mag;
        begin
            v   = ~code;
            t   = 16'({v[3:0], 3'b000}) + MuBias;
            t   = t << v[6:4];
            mag = t - MuBias;
            mu_decode = v[7] ? (16'd0 - mag) : mag;
        end
    endfunction

    function automatic logic [CodeWidth-1:0] mu_encode(input logic [SampleWidth-1:0] raw);
        logic [15:0]         sh;
        logic [7:0]          mask;
        logic [MagWidth-1:0] mag;
        logic [MagWidth-1:0] biased;
        logic [MagWidth-1:0] shifted;
        logic [2:0]          seg;
        logic                fit;
        begin
            sh   = {raw[15], raw[15], raw[15:2]};
            mask = sh[15] ? 8'h7F : 8'hFF;
            mag  = sh[15] ? 14'(16'd0 - sh) : sh[13:0];
            if (mag > MuClip)
            begin
                mag = MuClip;
            end
            biased = mag + MuEncBias;
            seg = 3'd0;
            fit = 1'b0;
            for (int i = 7; i >= 0; i--)
            begin
                if (biased <= 14'((1 << (i + 6)) - 1))
                begin
                    seg = 3'(i);
                    fit = 1'b1;
                end
            end
            shifted = biased >> ({1'b0, seg} + 4'd1);
            if (fit)
            begin
                mu_encode = {1'b0, seg, shifted[3:0]} ^ mask;
            end
            else
            begin
                mu_encode = 8'h7F ^ mask;
            end
        end
    endfunction

endpackage
`default_nettype wire

### design/mulaw_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mulaw_front
// Accepts samples, holds configuration and parity, runs the codec and
// decides how many results each word produces
// ----------------------------------------------------------------------------
module mulaw_front (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [mulaw_pkg::IndexWidth-1:0]   cfg_index,
    input  wire logic [mulaw_pkg::DataWidth-1:0]    cfg_data,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [mulaw_pkg::SampleWidth-1:0]  s_tdata,
    input  wire logic                               s_tlast,
    output logic                                    push,
    output mulaw_pkg::mulaw_item_t                  push_item,
    input  wire logic                               queue_full
);
    import mulaw_pkg::*;

    logic       direction_reg;
    logic [1:0] channel_mode_reg;
    logic       odd_reg;
    logic       odd_next;
    logic       accept;
    logic       drop;

    assign s_tready = !queue_full;
    assign accept   = s_tvalid && s_tready;
    assign drop     = (channel_mode_reg == ModeStereoToMono) && odd_reg;
    assign push     = accept && !drop;
    assign odd_next = s_tlast ? 1'b0 : !odd_reg;

    always_comb
    begin
        push_item.dup = (channel_mode_reg == ModeMonoToStereo);
        if (direction_reg)
        begin
            push_item.value = {8'h00, mu_encode(s_tdata)};
        end
        else
        begin
            push_item.value = mu_decode(s_tdata[CodeWidth-1:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg    <= 1'b0;
            channel_mode_reg <= ModeMonoPass;
            odd_reg          <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    RegDirection:   direction_reg    <= cfg_data[0];
                    RegChannelMode: channel_mode_reg <= cfg_data[1:0];
                    default:        ;
                endcase
            end
            if (accept)
            begin
                odd_reg <= odd_next;
            end
        end
    end

endmodule
`default_nettype wire

### design/mulaw_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mulaw_queue
// Short first-in first-out queue between the front and the back
// ----------------------------------------------------------------------------
module mulaw_queue #(
    parameter int DEPTH = mulaw_pkg::QueueDepth
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   push,
    input  mulaw_pkg::mulaw_item_t      push_item,
    output logic                        full,
    input  wire logic                   pop,
    output logic                        head_valid,
    output mulaw_pkg::mulaw_item_t      head_item
);
    import mulaw_pkg::*;

    localparam int PtrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntWidth = $clog2(DEPTH + 1);

    mulaw_item_t          mem [DEPTH];
    logic [PtrWidth-1:0]  wr_ptr_reg;
    logic [PtrWidth-1:0]  rd_ptr_reg;
    logic [CntWidth-1:0]  count_reg;
    logic                 do_push;
    logic                 do_pop;

    assign full       = (count_reg == CntWidth'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = mem[rd_ptr_reg];
    assign do_pop     = pop && head_valid;
    assign do_push    = push && !full;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PtrWidth'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PtrWidth'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

### design/mulaw_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mulaw_back
// Takes items from the queue and sends one or two result words through the
// output register
// ----------------------------------------------------------------------------
module mulaw_back (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    output logic                                    pop,
    input  wire logic                               head_valid,
    input  mulaw_pkg::mulaw_item_t                  head_item,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [mulaw_pkg::SampleWidth-1:0]       m_tdata,
    output logic                                    m_tlast
);
    import mulaw_pkg::*;

    logic                   valid_reg;
    logic [SampleWidth-1:0] data_reg;
    logic                   last_reg;
    logic                   repeat_reg;
    logic                   advance;

    assign advance  = !valid_reg || m_tready;
    assign pop      = advance && !repeat_reg && head_valid;
    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            data_reg <= head_item.value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            last_reg   <= 1'b0;
            repeat_reg <= 1'b0;
        end
        else if (advance)
        begin
            if (repeat_reg)
            begin
                // second copy of a duplicated word
                valid_reg  <= 1'b1;
                last_reg   <= 1'b1;
                repeat_reg <= 1'b0;
            end
            else if (head_valid)
            begin
                valid_reg  <= 1'b1;
                last_reg   <= !head_item.dup;
                repeat_reg <= head_item.dup;
            end
            else
            begin
                valid_reg <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

### design/mu_law_codec_channel_convert_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mu_law_codec_channel_convert_top
// G.711 mu-law encoder/decoder with channel layout conversion
//
// Input stream s_*: one sample word per transfer, s_tlast marks buffer end.
// Output stream m_*: one result word per transfer, m_tlast marks the final
// result caused by an input word.
// Configuration: cfg_we writes cfg_data to register cfg_index (0 direction,
// 1 channel mode); the user must write only while the stream is idle, as the
// block does not enforce it. A taken input word goes to a queue slot, then to
// the output register that drives m_tvalid.
// Throughput: one input word per cycle while the queue is not full. In
// mono-to-stereo mode each word yields two results and holds the output
// register until both are sent; stereo-to-mono mode drops odd positions.
// Reset clears configuration, buffer parity, queue and output register.
// When m_tready is low the output word holds and the queue fills; s_tready
// drops once the queue is full.
// ----------------------------------------------------------------------------
module mu_law_codec_channel_convert_top #(
    parameter int QUEUE_DEPTH = mulaw_pkg::QueueDepth
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [mulaw_pkg::IndexWidth-1:0]   cfg_index,
    input  wire logic [mulaw_pkg::DataWidth-1:0]    cfg_data,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [mulaw_pkg::SampleWidth-1:0]  s_tdata,   // sample_in
    input  wire logic                               s_tlast,   // buffer_end
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [mulaw_pkg::SampleWidth-1:0]       m_tdata,   // value_out
    output logic                                    m_tlast    // last_of_run
);
    import mulaw_pkg::*;

    logic        push;
    mulaw_item_t push_item;
    logic        queue_full;
    logic        pop;
    logic        head_valid;
    mulaw_item_t head_item;

    mulaw_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .push       (push),
        .push_item  (push_item),
        .queue_full (queue_full)
    );

    mulaw_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    mulaw_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule
`default_nettype wire

### test/mulaw_convert_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mulaw_convert_checker
// Watches the config port and both streams of the mu-law converter, predicts
// each output word from the accepted input words and compares them in order
// ----------------------------------------------------------------------------
module mulaw_convert_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [1:0]  cfg_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,   // sample_in
    input  logic        s_tlast,   // buffer_end
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,   // value_out
    input  logic        m_tlast,   // last_of_run
    output int          mismatches,
    output int          words_due
);

    localparam int ExpandBias = 132;
    localparam int ClipLevel  = 8159;
    localparam int EncodeBias = 33;

    typedef struct packed {
        logic [15:0] value;
        logic        last;
    } out_word_t;

    logic      dir_q;
    logic [1:0] mode_q;
    logic      odd_q;
    int        err_count;
    out_word_t awaited_words[$];

    function automatic logic [15:0] mulaw_expand(input logic [7:0] code);
        logic [7:0] inv;
        int         mag;
        begin
            inv = ~code;
            mag = ((int'(inv[3:0]) * 8 + ExpandBias) << inv[6:4]) - ExpandBias;
            return inv[7] ? 16'(-mag) : 16'(mag);
        end
    endfunction

    function automatic logic [7:0] mulaw_compress(input logic signed [15:0] pcm);
        int         s;
        int         mag;
        int         seg;
        logic [7:0] flip;
        begin
            // keep the sign while dropping the two low bits
            s    = int'(pcm) >>> 2;
            flip = (s < 0) ? 8'h7F : 8'hFF;
            mag  = (s < 0) ? -s : s;
            if (mag > ClipLevel)
            begin
                mag = ClipLevel;
            end
            mag = mag + EncodeBias;
            seg = 0;
            while (seg < 8 && mag > ((64 << seg) - 1))
            begin
                seg++;
            end
            if (seg == 8)
            begin
                return 8'h7F ^ flip;
            end
            return 8'((seg << 4) | ((mag >> (seg + 1)) & 15)) ^ flip;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        out_word_t   got;
        out_word_t   want;
        logic [15:0] val;
        if (!rst_n)
        begin
            dir_q     = 1'b0;
            mode_q    = mulaw_pkg::ModeMonoPass;
            odd_q     = 1'b0;
            err_count = 0;
            awaited_words.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == mulaw_pkg::RegDirection)
                begin
                    dir_q = cfg_data[0];
                end
                else if (cfg_index == mulaw_pkg::RegChannelMode)
                begin
                    mode_q = cfg_data[1:0];
                end
            end
            // retire before taking new input, since no result leaves in the cycle its input is taken
            if (m_tvalid && m_tready)
            begin
                got.value = m_tdata;
                got.last  = m_tlast;
                if (awaited_words.size() == 0)
                begin
                    err_count++;
                    $display("%0t: expected no word, actual value %h last %b",
                             $time, got.value, got.last);
                end
                else
                begin
                    want = awaited_words.pop_front();
                    if (got.value !== want.value || got.last !== want.last)
                    begin
                        err_count++;
                        $display("%0t: expected value %h last %b, actual value %h last %b",
                                 $time, want.value, want.last, got.value, got.last);
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                val = dir_q ? {8'h00, mulaw_compress(s_tdata)} : mulaw_expand(s_tdata[7:0]);
                case (mode_q)
                    mulaw_pkg::ModeMonoToStereo:
                    begin
                        awaited_words.push_back(out_word_t'{val, 1'b0});
                        awaited_words.push_back(out_word_t'{val, 1'b1});
                    end
                    mulaw_pkg::ModeStereoToMono:
                    begin
                        if (!odd_q)
                        begin
                            awaited_words.push_back(out_word_t'{val, 1'b1});
                        end
                    end
                    default:
                    begin
                        awaited_words.push_back(out_word_t'{val, 1'b1});
                    end
                endcase
                odd_q = s_tlast ? 1'b0 : !odd_q;
            end
        end
        mismatches <= err_count;
        words_due  <= awaited_words.size();
    end

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the mu-law converter through every direction and channel mode with
// directed corner samples and random buffers, random idling on both streams
// and one long output stall; the checker predicts and compares each word.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int CycleLimit  = 400000;
    localparam int PhaseWords  = 122;
    localparam int HoldCycles  = 300;
    localparam int DrainCycles = 8;
    localparam int PhaseCount  = 8;

    localparam logic DirDecode = 1'b0;
    localparam logic DirEncode = 1'b1;

    localparam logic [1:0] RegSpareLow  = 2'd2;
    localparam logic [1:0] RegSpareHigh = 2'd3;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [1:0]  cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic        m_tlast;
    int          mismatches;
    int          words_due;

    bit          src_idle;
    bit          snk_idle;
    bit          hold_req;

    logic [15:0] enc_probe [0:13];
    logic [15:0] dec_probe [0:5];
    logic        phase_dir [0:PhaseCount-1];
    logic [1:0]  phase_mode [0:PhaseCount-1];

    mu_law_codec_channel_convert_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    mulaw_convert_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .mismatches (mismatches),
        .words_due  (words_due)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    task automatic write_reg(input logic [1:0] idx, input logic [1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic configure(input logic dir, input logic [1:0] mode);
        write_reg($urandom_range(0, 1) ? RegSpareLow : RegSpareHigh, 2'($urandom));
        // upper data bit must be ignored by the direction register
        write_reg(mulaw_pkg::RegDirection, {1'($urandom), dir});
        write_reg(mulaw_pkg::RegChannelMode, mode);
    endtask

    task automatic send_word(input logic [15:0] data, input logic last);
        if (src_idle && $urandom_range(0, 7) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tlast  <= last;
        do @(posedge clk); while (!s_tready);
    endtask

    // wait for every word to drain, plus slack for dropped odd positions
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (words_due != 0) @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
    endtask

    function automatic logic [15:0] pick_pcm();
        logic [15:0] mag;
        case ($urandom_range(0, 3))
            0:       mag = 16'($urandom);
            1:       mag = 16'($urandom_range(0, 600));
            2:       mag = 16'($urandom_range(32600, 32767));
            default: mag = 16'($urandom) >> $urandom_range(1, 14);
        endcase
        return $urandom_range(0, 1) ? 16'(-mag) : mag;
    endfunction

    initial
    begin : sink
        int stall;
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HoldCycles) @(posedge clk);
                m_tready <= 1'b1;
            end
            else if (snk_idle && $urandom_range(0, 5) == 0)
            begin
                m_tready <= 1'b0;
                stall = $urandom_range(1, 15);
                repeat (stall) @(posedge clk);
                m_tready <= 1'b1;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CycleLimit)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("mu_law_codec_channel_convert_top test failed");
        $finish;
    end

    initial
    begin : stimulus
        int          buf_left;
        logic [15:0] word;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;
        src_idle  = 1'b1;
        snk_idle  = 1'b1;
        hold_req  = 1'b0;

        // zero, shift-to-zero, sign edges, full scale, clip edge, segment 0/1 edge
        enc_probe = '{16'h0000, 16'h0001, 16'h0003, 16'h0004, 16'hFFFF, 16'hFFFC,
                      16'hFFFB, 16'h7FFF, 16'h8000, 16'h7F7C, 16'h7F80, 16'h8084,
                      16'h007C, 16'h0078};
        // code extremes, sign boundary, ignored upper bits
        dec_probe = '{16'h0000, 16'h00FF, 16'h007F, 16'h0080, 16'hFF00, 16'hAA55};

        phase_dir  = '{DirEncode, DirDecode, DirEncode, DirDecode,
                       DirEncode, DirDecode, DirEncode, DirDecode};
        phase_mode = '{mulaw_pkg::ModeStereoToMono, mulaw_pkg::ModeStereoPass,
                       mulaw_pkg::ModeMonoToStereo, mulaw_pkg::ModeStereoToMono,
                       mulaw_pkg::ModeMonoPass, mulaw_pkg::ModeMonoToStereo,
                       mulaw_pkg::ModeStereoPass, mulaw_pkg::ModeMonoPass};

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        configure(DirEncode, mulaw_pkg::ModeMonoPass);
        foreach (enc_probe[i])
        begin
            send_word(enc_probe[i], 1'b0);
        end
        settle();

        configure(DirDecode, mulaw_pkg::ModeMonoToStereo);
        foreach (dec_probe[i])
        begin
            send_word(dec_probe[i], i == 5);
        end
        settle();

        // parity: even, odd, even+end, even+end, even
        configure(DirDecode, mulaw_pkg::ModeStereoToMono);
        send_word(16'h0011, 1'b0);
        send_word(16'h0022, 1'b0);
        send_word(16'h0033, 1'b1);
        send_word(16'h0044, 1'b1);
        send_word(16'h0055, 1'b0);
        settle();

        for (int p = 0; p < PhaseCount; p++)
        begin
            src_idle = (p % 3 != 1) && (p != PhaseCount - 1);
            snk_idle = (p % 3 != 2) && (p != PhaseCount - 1);
            configure(phase_dir[p], phase_mode[p]);
            buf_left = $urandom_range(1, 16);
            for (int n = 0; n < PhaseWords; n++)
            begin
                if (p == 2 && n == 30)
                begin
                    hold_req = 1'b1;
                end
                word = phase_dir[p] ? pick_pcm() : 16'($urandom);
                send_word(word, buf_left == 1);
                buf_left = (buf_left == 1) ? $urandom_range(1, 16) : buf_left - 1;
            end
            settle();
        end

        if (mismatches == 0 && words_due == 0)
        begin
            $display("mu_law_codec_channel_convert_top test passed");
        end
        else
        begin
            $display("mu_law_codec_channel_convert_top test failed");
        end
        $finish;
    end

endmodule

### filelist.f
design/mulaw_pkg.sv
design/mulaw_front.sv
design/mulaw_queue.sv
design/mulaw_back.sv
design/mu_law_codec_channel_convert_top.sv
test/mulaw_convert_checker.sv
test/tb_top.sv
